@@ design/gshc_pkg.sv @@
package gshc_pkg;

	localparam logic [1:0] REQ_CHECK = 2'd0;
	localparam logic [1:0] REQ_MPM   = 2'd1;
	localparam logic [1:0] REQ_SIZE  = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [5:0] SEL_CHECKS   = 6'd0;
	localparam logic [5:0] SEL_GENERIC  = 6'd1;
	localparam logic [5:0] SEL_SYN      = 6'd2;
	localparam logic [5:0] SEL_POSTSUM  = 6'd3;
	localparam logic [5:0] SEL_POSTPEAK = 6'd4;
	localparam logic [5:0] SEL_MPMSUM   = 6'd5;
	localparam logic [5:0] SEL_MPMPEAK  = 6'd6;
	localparam logic [5:0] SEL_MPMCHK   = 6'd7;
	localparam logic [5:0] SEL_OVERFLOW = 6'd8;
	localparam logic [5:0] SEL_BIN0     = 6'd9;

	localparam logic [1:0] REG_ACTIVE_GROUPS = 2'd0;
	localparam logic [1:0] REG_HIST_ENABLE   = 2'd1;
	localparam logic [1:0] REG_BIN_WIDTH     = 2'd2;
	localparam logic [1:0] REG_BIN_COUNT     = 2'd3;

	// slots of the counters in one group word
	localparam int F_CHK  = 0;
	localparam int F_GEN  = 1;
	localparam int F_SYN  = 2;
	localparam int F_PSUM = 3;
	localparam int F_MSUM = 4;
	localparam int F_MCHK = 5;
	localparam int F_OVF  = 6;
	localparam int F_NUM  = 7;
	localparam int PEAK_BITS = 16;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_MOD   = 6'b010000,
		ST_OUT   = 6'b100000
	} gshc_state_t;

endpackage

@@ design/gshc_div.sv @@
module gshc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign fits   = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'd32;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 6'd1;
			done_q <= (cnt_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/group_stats_histogram_counters.sv @@
// Per-group statistics table. Requests arrive on the s_ stream; only a counter read
// returns a result on the m_ stream, which is registered, so the next request is taken
// while a read result waits. After reset a clearing pass writes zero to every entry,
// one bin address per cycle over all GROUPS*MAX_BINS addresses (8192 at the defaults);
// no request is taken during it. Each request then reads its group word and bin entry
// from registered-read memories, updates and writes back before the next is accepted:
// check and mpm events go through read and modify, a counter read also output; a size
// sample with a bin index first runs the 32-step restoring divider, buffer_size/bin_width.
module group_stats_histogram_counters #(
	parameter int GROUPS     = 256,
	parameter int MAX_BINS   = 32,
	parameter int COUNT_BITS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// group_id, prefilter_ran, used_syn_store, post_filter_count, mpm_match_count,
	// mpm_checks_add, buffer_size, counter_select
	input  logic [95:0]  s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_value
	output logic [47:0]  m_tdata,
	// read_ok
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CB     = COUNT_BITS;
	localparam int NTOT   = GROUPS * MAX_BINS;
	localparam int GA     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int BA     = (NTOT > 1) ? $clog2(NTOT) : 1;
	localparam int BW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int GW     = gshc_pkg::F_NUM * CB + 2 * gshc_pkg::PEAK_BITS;
	localparam int PP_OFF = gshc_pkg::F_NUM * CB;
	localparam int MP_OFF = PP_OFF + gshc_pkg::PEAK_BITS;

	function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CB] ? '1 : s[CB-1:0];
	endfunction

	gshc_pkg::gshc_state_t st_q;

	logic [8:0]  active_q;
	logic        hen_q;
	logic [31:0] bwidth_q;
	logic [5:0]  bcount_q;

	logic [1:0]  req_q;
	logic [7:0]  g_q;
	logic        pf_q;
	logic        syn_q;
	logic [15:0] post_q;
	logic [15:0] mpm_q;
	logic [15:0] mchk_q;
	logic [5:0]  sel_q;
	logic        upd_q;
	logic        ok_q;
	logic        ovf_q;
	logic [BW-1:0] bin_q;
	logic [47:0] rval_q;
	logic [BA-1:0] clr_q;

	logic [GW-1:0] gmem [GROUPS];
	logic [CB-1:0] bmem [NTOT];
	logic [GW-1:0] gm_rdata;
	logic [CB-1:0] bm_rdata;
	logic          gm_we;
	logic [GA-1:0] gm_waddr;
	logic [GW-1:0] gm_wdata;
	logic          bm_we;
	logic [BA-1:0] bm_waddr;
	logic [CB-1:0] bm_wdata;
	logic [GA-1:0] g_idx;
	logic [BA-1:0] b_addr;
	logic [GW-1:0] nw;
	logic          grp_upd;
	logic          bin_upd;
	logic [47:0]   rval;

	logic [1:0]  in_req;
	logic [7:0]  in_g;
	logic [31:0] in_size;
	logic [5:0]  in_sel;
	logic [8:0]  nb;
	logic        in_valid;
	logic        in_sel_ok;
	logic [8:0]  in_bin;
	logic        accept;
	logic        need_div;
	logic        div_done;
	logic [31:0] div_quo;
	logic        out_load;
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tuser_q;
	logic        cfg_wr;

	assign in_req  = s_tuser;
	assign in_g    = s_tdata[7:0];
	assign in_size = s_tdata[89:58];
	assign in_sel  = s_tdata[95:90];

	assign nb = (9'(bcount_q) > 9'(MAX_BINS)) ? 9'(MAX_BINS) : 9'(bcount_q);
	assign in_valid = ({1'b0, in_g} < active_q) && (32'(in_g) < 32'(GROUPS));
	assign in_bin = 9'(in_sel) - 9'(gshc_pkg::SEL_BIN0);
	assign in_sel_ok = (in_sel <= gshc_pkg::SEL_OVERFLOW) || (in_bin < nb);

	assign s_tready = (st_q == gshc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign need_div = (in_req == gshc_pkg::REQ_SIZE) && (bwidth_q != '0) && (nb != '0);

	gshc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && need_div),
		.dividend (in_size),
		.divisor  (bwidth_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_load = (st_q == gshc_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= gshc_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				gshc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + BA'(1);
					if (clr_q == BA'(NTOT - 1)) begin
						st_q <= gshc_pkg::ST_IDLE;
					end
				end
				gshc_pkg::ST_IDLE: begin
					if (accept) begin
						st_q <= need_div ? gshc_pkg::ST_DIV : gshc_pkg::ST_READ;
					end
				end
				gshc_pkg::ST_DIV: begin
					if (div_done) begin
						st_q <= gshc_pkg::ST_READ;
					end
				end
				gshc_pkg::ST_READ: begin
					st_q <= gshc_pkg::ST_MOD;
				end
				gshc_pkg::ST_MOD: begin
					st_q <= (req_q == gshc_pkg::REQ_READ) ? gshc_pkg::ST_OUT : gshc_pkg::ST_IDLE;
				end
				gshc_pkg::ST_OUT: begin
					if (out_load) begin
						st_q <= gshc_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= gshc_pkg::ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_req;
			g_q    <= in_g;
			pf_q   <= s_tdata[8];
			syn_q  <= s_tdata[9];
			post_q <= s_tdata[25:10];
			mpm_q  <= s_tdata[41:26];
			mchk_q <= s_tdata[57:42];
			sel_q  <= in_sel;
			ok_q   <= in_valid && in_sel_ok;
			upd_q  <= in_valid && ((in_req != gshc_pkg::REQ_SIZE) || hen_q);
			ovf_q  <= 1'b1;
			bin_q  <= BW'(in_bin);
		end else if ((st_q == gshc_pkg::ST_DIV) && div_done) begin
			ovf_q <= div_quo >= 32'(nb);
			bin_q <= div_quo[BW-1:0];
		end
		if (st_q == gshc_pkg::ST_MOD) begin
			rval_q <= rval;
		end
	end

	assign g_idx  = GA'(g_q);
	assign b_addr = BA'(g_idx) * BA'(MAX_BINS) + BA'(bin_q);

	always_comb begin
		nw = gm_rdata;
		case (req_q)
			gshc_pkg::REQ_CHECK: begin
				nw[gshc_pkg::F_CHK*CB +: CB] = sat_add(gm_rdata[gshc_pkg::F_CHK*CB +: CB], CB'(1));
				if (pf_q && syn_q) begin
					nw[gshc_pkg::F_SYN*CB +: CB] =
						sat_add(gm_rdata[gshc_pkg::F_SYN*CB +: CB], CB'(1));
				end
				if (pf_q && !syn_q) begin
					nw[gshc_pkg::F_GEN*CB +: CB] =
						sat_add(gm_rdata[gshc_pkg::F_GEN*CB +: CB], CB'(1));
				end
				nw[gshc_pkg::F_PSUM*CB +: CB] =
					sat_add(gm_rdata[gshc_pkg::F_PSUM*CB +: CB], CB'(post_q));
				nw[gshc_pkg::F_MSUM*CB +: CB] =
					sat_add(gm_rdata[gshc_pkg::F_MSUM*CB +: CB], CB'(mpm_q));
				if (post_q > gm_rdata[PP_OFF +: 16]) begin
					nw[PP_OFF +: 16] = post_q;
				end
				if (mpm_q > gm_rdata[MP_OFF +: 16]) begin
					nw[MP_OFF +: 16] = mpm_q;
				end
			end
			gshc_pkg::REQ_MPM: begin
				nw[gshc_pkg::F_MCHK*CB +: CB] =
					sat_add(gm_rdata[gshc_pkg::F_MCHK*CB +: CB], CB'(mchk_q));
			end
			default: begin
				nw[gshc_pkg::F_OVF*CB +: CB] = sat_add(gm_rdata[gshc_pkg::F_OVF*CB +: CB], CB'(1));
			end
		endcase
	end

	assign grp_upd = upd_q && ((req_q == gshc_pkg::REQ_CHECK) || (req_q == gshc_pkg::REQ_MPM) ||
		((req_q == gshc_pkg::REQ_SIZE) && ovf_q));
	assign bin_upd = upd_q && (req_q == gshc_pkg::REQ_SIZE) && !ovf_q;

	always_comb begin
		if (st_q == gshc_pkg::ST_CLEAR) begin
			gm_we    = (32'(clr_q) < 32'(GROUPS));
			gm_waddr = GA'(clr_q);
			gm_wdata = '0;
			bm_we    = 1'b1;
			bm_waddr = clr_q;
			bm_wdata = '0;
		end else begin
			gm_we    = (st_q == gshc_pkg::ST_MOD) && grp_upd;
			gm_waddr = g_idx;
			gm_wdata = nw;
			bm_we    = (st_q == gshc_pkg::ST_MOD) && bin_upd;
			bm_waddr = b_addr;
			bm_wdata = sat_add(bm_rdata, CB'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (gm_we) begin
			gmem[gm_waddr] <= gm_wdata;
		end
		gm_rdata <= gmem[g_idx];
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bmem[bm_waddr] <= bm_wdata;
		end
		bm_rdata <= bmem[b_addr];
	end

	always_comb begin
		case (sel_q)
			gshc_pkg::SEL_CHECKS:   rval = 48'(gm_rdata[gshc_pkg::F_CHK*CB +: CB]);
			gshc_pkg::SEL_GENERIC:  rval = 48'(gm_rdata[gshc_pkg::F_GEN*CB +: CB]);
			gshc_pkg::SEL_SYN:      rval = 48'(gm_rdata[gshc_pkg::F_SYN*CB +: CB]);
			gshc_pkg::SEL_POSTSUM:  rval = 48'(gm_rdata[gshc_pkg::F_PSUM*CB +: CB]);
			gshc_pkg::SEL_POSTPEAK: rval = 48'(gm_rdata[PP_OFF +: 16]);
			gshc_pkg::SEL_MPMSUM:   rval = 48'(gm_rdata[gshc_pkg::F_MSUM*CB +: CB]);
			gshc_pkg::SEL_MPMPEAK:  rval = 48'(gm_rdata[MP_OFF +: 16]);
			gshc_pkg::SEL_MPMCHK:   rval = 48'(gm_rdata[gshc_pkg::F_MCHK*CB +: CB]);
			gshc_pkg::SEL_OVERFLOW: rval = 48'(gm_rdata[gshc_pkg::F_OVF*CB +: CB]);
			default:                rval = 48'(bm_rdata);
		endcase
		if (!ok_q) begin
			rval = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= rval_q;
			m_tuser_q <= ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 9'd256;
			hen_q    <= 1'b0;
			bwidth_q <= 32'd1024;
			bcount_q <= 6'd20;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				gshc_pkg::REG_ACTIVE_GROUPS: active_q <= pwdata[8:0];
				gshc_pkg::REG_HIST_ENABLE:   hen_q    <= pwdata[0];
				gshc_pkg::REG_BIN_WIDTH:     bwidth_q <= pwdata;
				gshc_pkg::REG_BIN_COUNT:     bcount_q <= pwdata[5:0];
				default:                     bcount_q <= bcount_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			gshc_pkg::REG_ACTIVE_GROUPS: prdata = 32'(active_q);
			gshc_pkg::REG_HIST_ENABLE:   prdata = 32'(hen_q);
			gshc_pkg::REG_BIN_WIDTH:     prdata = bwidth_q;
			gshc_pkg::REG_BIN_COUNT:     prdata = 32'(bcount_q);
			default:                     prdata = '0;
		endcase
	end

	a_clear_only_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		(gm_we && bm_we) |-> (st_q == gshc_pkg::ST_CLEAR))
		else $error("group and bin memories written together outside clearing");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("read result overwrote an undelivered result");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == gshc_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(st_q == gshc_pkg::ST_OUT && req_q == gshc_pkg::REQ_READ))
		else $error("result raised without a read request");

endmodule
